// File: design/flue_pkg.sv
// ----------------------------------------------------------------------------
// flue_pkg: shared types, constants and arithmetic helpers
// Payload structs, command and register codes, sequencer states, Q16.16
// saturation helpers and the exp function used to build the sigmoid table.
// ----------------------------------------------------------------------------
`default_nettype none

package flue_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_FEATURE = 2'd0,
      CMD_LOAD_LABEL   = 2'd1,
      CMD_RUN_STEP     = 2'd2,
      CMD_READ_MEAN    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [9:0]         sample_index;
      logic [3:0]         coord_index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mean_value;
      logic [3:0]         mean_coord;
   } rsp_type;

   localparam logic [1:0] CSR_STEP_SIZE        = 2'd0;
   localparam logic [1:0] CSR_REG_WEIGHT       = 2'd1;
   localparam logic [1:0] CSR_FEATURE_COUNT    = 2'd2;
   localparam logic [1:0] CSR_INV_SAMPLE_COUNT = 2'd3;

   localparam logic [30:0] STEP_SIZE_RESET     = 31'd6554;
   localparam logic [30:0] REG_WEIGHT_RESET    = 31'd0;
   localparam logic [4:0]  FEATURE_COUNT_RESET = 5'd16;
   localparam logic [16:0] INV_COUNT_RESET     = 17'd64;
   localparam logic [16:0] INV_COUNT_MAX       = 17'd65536;

   localparam longint Q_ONE   = 65536;
   localparam longint U_LIMIT = 524288;
   localparam longint Q30_ONE = 1073741824;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LBL, ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC,
      ST_U_MUL, ST_U_SAT, ST_T, ST_TY_MUL, ST_TY,
      ST_UP_RD, ST_G1, ST_G2, ST_G3, ST_G4,
      ST_CM_RD, ST_CM1, ST_CM2, ST_RD, ST_PUSH
   } state_type;

   // Write enables of the storage arrays.
   typedef struct packed {
      logic fx;
      logic lb;
      logic z;
      logic mn;
      logic dl;
   } we_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product back to Q16.16: floor shift, then saturate.
   function automatic logic signed [31:0] qnorm(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      return sat32(s);
   endfunction

   // exp(-v) in Q30 for v in Q16.16, 0 <= v <= 8; elaboration use only.
   function automatic longint exp_neg_q30(input longint v);
      longint k, f, pos, neg, term, ek;
      k = v >>> 16;
      f = (v & 64'hFFFF) << 14;
      pos = Q30_ONE;
      neg = 0;
      term = Q30_ONE;
      if (k > 8) k = 8;
      term = ((term * f) >>> 30) / 1;  neg += term;
      term = ((term * f) >>> 30) / 2;  pos += term;
      term = ((term * f) >>> 30) / 3;  neg += term;
      term = ((term * f) >>> 30) / 4;  pos += term;
      term = ((term * f) >>> 30) / 5;  neg += term;
      term = ((term * f) >>> 30) / 6;  pos += term;
      term = ((term * f) >>> 30) / 7;  neg += term;
      term = ((term * f) >>> 30) / 8;  pos += term;
      term = ((term * f) >>> 30) / 9;  neg += term;
      term = ((term * f) >>> 30) / 10; pos += term;
      term = ((term * f) >>> 30) / 11; neg += term;
      term = ((term * f) >>> 30) / 12; pos += term;
      term = ((term * f) >>> 30) / 13; neg += term;
      term = ((term * f) >>> 30) / 14; pos += term;
      case (k)
         0: ek = 1073741824;
         1: ek = 395007542;
         2: ek = 145315154;
         3: ek = 53458458;
         4: ek = 19666267;
         5: ek = 7234816;
         6: ek = 2661540;
         7: ek = 979126;
         default: ek = 360200;
      endcase
      return (ek * (pos - neg)) >>> 30;
   endfunction

endpackage

`default_nettype wire

// File: design/flue_sigmoid.sv
// ----------------------------------------------------------------------------
// flue_sigmoid: logistic term lookup
// Clamps u to [-8, 8], maps it to the nearest entry of a constant table of
// 1/(1+exp(u)) built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module flue_sigmoid #(
   parameter int SIGMOID_TABLE_DEPTH = 256
) (
   input  wire logic signed [31:0] u,
   output logic [31:0]             t
);

   localparam int TW = $clog2(SIGMOID_TABLE_DEPTH);
   localparam longint D1 = SIGMOID_TABLE_DEPTH - 1;

   logic [31:0] tab [SIGMOID_TABLE_DEPTH];

   for (genvar gi = 0; gi < SIGMOID_TABLE_DEPTH; gi++) begin : g_tab
      localparam longint UI  = (gi * 2 * flue_pkg::U_LIMIT + D1 / 2) / D1 - flue_pkg::U_LIMIT;
      localparam longint VI  = (UI < 0) ? -UI : UI;
      localparam longint EI  = flue_pkg::exp_neg_q30(VI);
      localparam longint DEN = flue_pkg::Q30_ONE + EI;
      localparam longint NUM = (UI >= 0) ? EI * flue_pkg::Q_ONE
                                         : flue_pkg::Q30_ONE * flue_pkg::Q_ONE;
      localparam logic [31:0] ENT = 32'((NUM + DEN / 2) / DEN);
      assign tab[gi] = ENT;
   end

   logic [20:0] shifted;
   logic [47:0] scaled;
   logic [27:0] idx_raw;
   logic [TW-1:0] idx;

   always_comb begin
      if (u > 32'sd524288) begin
         shifted = 21'd1048576;
      end else if (u < -32'sd524288) begin
         shifted = 21'd0;
      end else begin
         shifted = 21'(u + 32'sd524288);
      end
      scaled  = 48'(shifted) * 48'(D1) + 48'd524288;
      idx_raw = scaled[47:20];
      if (idx_raw > 28'(D1)) begin
         idx = TW'(D1);
      end else begin
         idx = idx_raw[TW-1:0];
      end
      t = tab[idx];
   end

endmodule

`default_nettype wire

// File: design/flue_store.sv
// ----------------------------------------------------------------------------
// flue_store: state memories
// Feature matrix, labels, per-sample z table, mean vector and delta scratch,
// each a single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module flue_store #(
   parameter int MAX_SAMPLES = 1024,
   parameter int MAX_DIM     = 16
) (
   input  wire logic                                clock,
   input  wire flue_pkg::we_type                    we,
   input  wire logic [$clog2(MAX_SAMPLES*MAX_DIM)-1:0] fx_addr,
   input  wire logic [$clog2(MAX_SAMPLES*MAX_DIM)-1:0] z_addr,
   input  wire logic [$clog2(MAX_SAMPLES)-1:0]      lb_addr,
   input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] mn_addr,
   input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] dl_addr,
   input  wire logic signed [31:0]                  fx_wdata,
   input  wire logic signed [31:0]                  lb_wdata,
   input  wire logic signed [31:0]                  z_wdata,
   input  wire logic signed [31:0]                  mn_wdata,
   input  wire logic signed [31:0]                  dl_wdata,
   output logic signed [31:0]                       fx_rdata,
   output logic signed [31:0]                       lb_rdata,
   output logic signed [31:0]                       z_rdata,
   output logic signed [31:0]                       mn_rdata,
   output logic signed [31:0]                       dl_rdata
);

   localparam int TOTAL = MAX_SAMPLES * MAX_DIM;
   localparam int MDEPTH = (MAX_DIM > 1) ? MAX_DIM : 2;

   logic signed [31:0] fx_mem [TOTAL];
   logic signed [31:0] z_mem  [TOTAL];
   logic signed [31:0] lb_mem [MAX_SAMPLES];
   logic signed [31:0] mn_mem [MDEPTH];
   logic signed [31:0] dl_mem [MDEPTH];

   always_ff @(posedge clock) begin
      if (we.fx) begin
         fx_mem[fx_addr] <= fx_wdata;
      end
      fx_rdata <= fx_mem[fx_addr];
   end

   always_ff @(posedge clock) begin
      if (we.z) begin
         z_mem[z_addr] <= z_wdata;
      end
      z_rdata <= z_mem[z_addr];
   end

   always_ff @(posedge clock) begin
      if (we.lb) begin
         lb_mem[lb_addr] <= lb_wdata;
      end
      lb_rdata <= lb_mem[lb_addr];
   end

   always_ff @(posedge clock) begin
      if (we.mn) begin
         mn_mem[mn_addr] <= mn_wdata;
      end
      mn_rdata <= mn_mem[mn_addr];
   end

   always_ff @(posedge clock) begin
      if (we.dl) begin
         dl_mem[dl_addr] <= dl_wdata;
      end
      dl_rdata <= dl_mem[dl_addr];
   end

endmodule

`default_nettype wire

// File: design/finito_logistic_update_engine.sv
// ----------------------------------------------------------------------------
// finito_logistic_update_engine: Finito logistic-regression step engine
// Commands load features and labels, run one update step on a sample, or
// read back one coordinate of the mean vector, all in Q16.16.
// ----------------------------------------------------------------------------
// Usage: words enter on req_valid/req_ready and one response word per read
// mean command leaves on rsp_valid/rsp_ready. The csr_ port writes the four
// registers at any edge where csr_write_enable is high and reset is low.
// After reset the block sweeps the z table and the mean vector to zero, one
// entry a cycle; req_ready stays low until the sweep is done.
// Loads are written in the same cycle they are accepted. The response word
// of a read mean is registered from ST_PUSH, after ST_RD. A step keeps
// req_ready low while every coordinate in use is visited three times through
// the single read/modify/write port of each memory, with at most two
// multiplies a cycle. The response sits in an output register; while it is
// not taken a further read mean waits in ST_PUSH with req_ready low, so
// other commands go ahead only until such a read is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module finito_logistic_update_engine #(
   parameter int MAX_SAMPLES         = 1024,
   parameter int MAX_DIM             = 16,
   parameter int SIGMOID_TABLE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire flue_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output flue_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [30:0]       csr_write_data
);

   localparam int TOTAL = MAX_SAMPLES * MAX_DIM;
   localparam int AW = $clog2(TOTAL);
   localparam int RW = $clog2(MAX_SAMPLES);
   localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // Configuration registers.
   logic [30:0] step_ff, weight_ff;
   logic [4:0]  count_ff;
   logic [16:0] inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= flue_pkg::STEP_SIZE_RESET;
         weight_ff <= flue_pkg::REG_WEIGHT_RESET;
         count_ff  <= flue_pkg::FEATURE_COUNT_RESET;
         inv_ff    <= flue_pkg::INV_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            flue_pkg::CSR_STEP_SIZE:     step_ff   <= csr_write_data;
            flue_pkg::CSR_REG_WEIGHT:    weight_ff <= csr_write_data;
            flue_pkg::CSR_FEATURE_COUNT: count_ff  <= csr_write_data[4:0];
            flue_pkg::CSR_INV_SAMPLE_COUNT: inv_ff <= csr_write_data[16:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] last_c;
   logic signed [31:0] alpha, weight, inv_n;

   always_comb begin
      if (count_ff == 5'd0) begin
         last_c = '0;
      end else if (32'(count_ff) > MAX_DIM) begin
         last_c = DW'(MAX_DIM - 1);
      end else begin
         last_c = DW'(count_ff - 5'd1);
      end
      alpha  = signed'({1'b0, step_ff});
      weight = signed'({1'b0, weight_ff});
      inv_n  = (inv_ff > flue_pkg::INV_COUNT_MAX) ? 32'sd65536 : signed'({15'd0, inv_ff});
   end

   // Sequencer and datapath registers.
   flue_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [DW-1:0] c_ff, c_in;
   logic [RW-1:0] row_ff, row_in;
   logic [3:0]    coord_ff, coord_in;
   logic signed [63:0] acc_ff, acc_in, pa_ff, pa_in, pb_ff, pb_in;
   logic signed [31:0] u_ff, u_in, t_ff, t_in, ty_ff, ty_in, g_ff, g_in;
   logic signed [31:0] mh_ff, mh_in, zh_ff, zh_in;
   logic rsp_valid_ff, rsp_valid_in;
   flue_pkg::rsp_type rsp_ff, rsp_in;

   flue_pkg::we_type we;
   logic [AW-1:0] fx_addr, z_addr, row_base;
   logic [RW-1:0] lb_addr;
   logic [DW-1:0] mn_addr;
   logic signed [31:0] z_wdata, mn_wdata, dl_wdata;
   logic signed [31:0] fx_rd, lb_rd, z_rd, mn_rd, dl_rd, t_lut;
   logic row_ok, coord_ok, take;
   logic signed [63:0] sum;

   flue_store #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .MAX_DIM(MAX_DIM)
   ) u_store (
      .clock(clock),
      .we(we),
      .fx_addr(fx_addr),
      .z_addr(z_addr),
      .lb_addr(lb_addr),
      .mn_addr(mn_addr),
      .dl_addr(c_ff),
      .fx_wdata(req_data.value),
      .lb_wdata(req_data.value),
      .z_wdata(z_wdata),
      .mn_wdata(mn_wdata),
      .dl_wdata(dl_wdata),
      .fx_rdata(fx_rd),
      .lb_rdata(lb_rd),
      .z_rdata(z_rd),
      .mn_rdata(mn_rd),
      .dl_rdata(dl_rd)
   );

   flue_sigmoid #(
      .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
   ) u_sigmoid (
      .u(u_ff),
      .t(t_lut)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flue_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff     <= c_in;
      row_ff   <= row_in;
      coord_ff <= coord_in;
      acc_ff   <= acc_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      u_ff     <= u_in;
      t_ff     <= t_in;
      ty_ff    <= ty_in;
      g_ff     <= g_in;
      mh_ff    <= mh_in;
      zh_ff    <= zh_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == flue_pkg::ST_IDLE);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign row_ok    = (32'(req_data.sample_index) < MAX_SAMPLES);
   assign coord_ok  = (32'(req_data.coord_index) < MAX_DIM);
   assign row_base  = AW'(row_ff) * AW'(MAX_DIM) + AW'(c_ff);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      c_in     = c_ff;
      row_in   = row_ff;
      coord_in = coord_ff;
      acc_in   = acc_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      u_in     = u_ff;
      t_in     = t_ff;
      ty_in    = ty_ff;
      g_in     = g_ff;
      mh_in    = mh_ff;
      zh_in    = zh_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      we       = '0;
      fx_addr  = row_base;
      z_addr   = row_base;
      lb_addr  = row_ff;
      mn_addr  = c_ff;
      z_wdata  = '0;
      mn_wdata = '0;
      dl_wdata = '0;
      sum      = '0;

      unique case (state_ff)
         flue_pkg::ST_CLEAR: begin
            z_addr = clr_ff;
            we.z   = 1'b1;
            if (32'(clr_ff) < MAX_DIM) begin
               mn_addr = clr_ff[DW-1:0];
               we.mn   = 1'b1;
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(TOTAL - 1)) begin
               state_in = flue_pkg::ST_IDLE;
            end
         end
         flue_pkg::ST_IDLE: begin
            fx_addr = AW'(RW'(req_data.sample_index)) * AW'(MAX_DIM)
                      + AW'(DW'(req_data.coord_index));
            lb_addr = RW'(req_data.sample_index);
            row_in   = RW'(req_data.sample_index);
            coord_in = req_data.coord_index;
            c_in     = '0;
            acc_in   = '0;
            if (take) begin
               unique case (req_data.command)
                  flue_pkg::CMD_LOAD_FEATURE: we.fx = row_ok && coord_ok;
                  flue_pkg::CMD_LOAD_LABEL:   we.lb = row_ok;
                  flue_pkg::CMD_RUN_STEP: begin
                     if (row_ok) state_in = flue_pkg::ST_LBL;
                  end
                  flue_pkg::CMD_READ_MEAN:    state_in = flue_pkg::ST_RD;
                  default: ;
               endcase
            end
         end
         flue_pkg::ST_LBL: state_in = flue_pkg::ST_DOT_RD;
         flue_pkg::ST_DOT_RD: state_in = flue_pkg::ST_DOT_MUL;
         flue_pkg::ST_DOT_MUL: begin
            pa_in    = mn_rd * fx_rd;
            state_in = flue_pkg::ST_DOT_ACC;
         end
         flue_pkg::ST_DOT_ACC: begin
            acc_in = acc_ff + (pa_ff >>> 16);
            if (c_ff == last_c) begin
               c_in     = '0;
               state_in = flue_pkg::ST_U_MUL;
            end else begin
               c_in     = c_ff + DW'(1);
               state_in = flue_pkg::ST_DOT_RD;
            end
         end
         flue_pkg::ST_U_MUL: begin
            pa_in    = lb_rd * flue_pkg::sat32(acc_ff);
            state_in = flue_pkg::ST_U_SAT;
         end
         flue_pkg::ST_U_SAT: begin
            u_in     = flue_pkg::qnorm(pa_ff);
            state_in = flue_pkg::ST_T;
         end
         flue_pkg::ST_T: begin
            t_in     = t_lut;
            state_in = flue_pkg::ST_TY_MUL;
         end
         flue_pkg::ST_TY_MUL: begin
            pa_in    = t_ff * lb_rd;
            state_in = flue_pkg::ST_TY;
         end
         flue_pkg::ST_TY: begin
            ty_in    = flue_pkg::qnorm(pa_ff);
            state_in = flue_pkg::ST_UP_RD;
         end
         flue_pkg::ST_UP_RD: state_in = flue_pkg::ST_G1;
         flue_pkg::ST_G1: begin
            pa_in    = ty_ff * fx_rd;
            pb_in    = weight * mn_rd;
            mh_in    = mn_rd;
            zh_in    = z_rd;
            state_in = flue_pkg::ST_G2;
         end
         flue_pkg::ST_G2: begin
            sum      = 64'sd0 - flue_pkg::qnorm(pa_ff) + flue_pkg::qnorm(pb_ff);
            g_in     = flue_pkg::sat32(sum);
            state_in = flue_pkg::ST_G3;
         end
         flue_pkg::ST_G3: begin
            pa_in    = alpha * g_ff;
            state_in = flue_pkg::ST_G4;
         end
         flue_pkg::ST_G4: begin
            sum      = 64'(mh_ff) - zh_ff - flue_pkg::qnorm(pa_ff);
            dl_wdata = flue_pkg::sat32(sum);
            we.dl    = 1'b1;
            if (c_ff == last_c) begin
               c_in     = '0;
               state_in = flue_pkg::ST_CM_RD;
            end else begin
               c_in     = c_ff + DW'(1);
               state_in = flue_pkg::ST_UP_RD;
            end
         end
         flue_pkg::ST_CM_RD: state_in = flue_pkg::ST_CM1;
         flue_pkg::ST_CM1: begin
            sum      = 64'(z_rd) + dl_rd;
            z_wdata  = flue_pkg::sat32(sum);
            we.z     = 1'b1;
            pa_in    = dl_rd * inv_n;
            mh_in    = mn_rd;
            state_in = flue_pkg::ST_CM2;
         end
         flue_pkg::ST_CM2: begin
            sum      = 64'(mh_ff) + flue_pkg::qnorm(pa_ff);
            mn_wdata = flue_pkg::sat32(sum);
            we.mn    = 1'b1;
            if (c_ff == last_c) begin
               state_in = flue_pkg::ST_IDLE;
            end else begin
               c_in     = c_ff + DW'(1);
               state_in = flue_pkg::ST_CM_RD;
            end
         end
         flue_pkg::ST_RD: begin
            mn_addr  = DW'(coord_ff);
            state_in = flue_pkg::ST_PUSH;
         end
         flue_pkg::ST_PUSH: begin
            mn_addr = DW'(coord_ff);
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.mean_coord  = coord_ff;
               rsp_in.mean_value  = (32'(coord_ff) < MAX_DIM) ? mn_rd : 32'sd0;
               state_in           = flue_pkg::ST_IDLE;
            end
         end
         default: state_in = flue_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire
